>>> design/csf_pkg.sv
// Shared types and constants for the cluster size filter with label compaction.
package csf_pkg;

  localparam int unsigned LABEL_W      = 8;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned MIN_PIXELS_W = 21;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;

  localparam logic [MIN_PIXELS_W-1:0] MIN_PIXELS_INIT = MIN_PIXELS_W'(1);
  localparam logic [LABEL_W-1:0]      CLASS_COUNT_INIT = LABEL_W'(0);

  localparam logic REG_MIN_PIXELS  = 1'b0;
  localparam logic REG_CLASS_COUNT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_COUNT   = 2'd1,
    CMD_BUILD   = 2'd2,
    CMD_RELABEL = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT_WR,
    ST_RELABEL_OUT,
    ST_BUILD_RUN,
    ST_BUILD_DONE
  } back_state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic               cluster;
    logic [LABEL_W-1:0] label;
  } item_t;

endpackage

>>> design/csf_if.sv
// Valid/ready channel interfaces for pixel items and result items.
interface csf_in_if;
  logic                          valid;
  logic                          ready;
  logic [csf_pkg::CMD_W-1:0]     command;
  logic [csf_pkg::LABEL_W-1:0]   pixel_label;

  modport source (output valid, output command, output pixel_label, input ready);
  modport sink   (input valid, input command, input pixel_label, output ready);
endinterface

interface csf_out_if;
  logic                          valid;
  logic                          ready;
  logic [csf_pkg::LABEL_W-1:0]   new_label;
  logic [csf_pkg::LABEL_W-1:0]   kept_clusters;
  logic                          count_saturated;

  modport source (output valid, output new_label, output kept_clusters,
                  output count_saturated, input ready);
  modport sink   (input valid, input new_label, input kept_clusters,
                  input count_saturated, output ready);
endinterface

>>> design/csf_front.sv
// Front end: accept pixel items and classify command and label.
module csf_front #(
  parameter int unsigned NUM_LABELS = 254
) (
  csf_in_if.sink         in_i,
  input  logic           full_i,
  output logic           push_o,
  output csf_pkg::item_t item_o
);
  import csf_pkg::*;

  localparam logic [LABEL_W-1:0] LABEL_MAX = LABEL_W'(NUM_LABELS);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    item_o.cmd     = cmd_e'(in_i.command);
    item_o.label   = in_i.pixel_label;
    item_o.cluster = (in_i.pixel_label != '0) && (in_i.pixel_label <= LABEL_MAX);
  end

endmodule

>>> design/csf_queue.sv
// Two-entry queue of classified items between front and back end.
module csf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  csf_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output csf_pkg::item_t item_o
);
  import csf_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> design/csf_back.sv
// Back end: counter and remap memories, build walk and result register.
module csf_back #(
  parameter int unsigned COUNT_BITS = 21,
  parameter int unsigned NUM_LABELS = 254
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  csf_pkg::item_t                      item_i,
  output logic                                pop_o,
  input  logic [csf_pkg::MIN_PIXELS_W-1:0]    min_pixels_i,
  input  logic [csf_pkg::LABEL_W-1:0]         class_count_i,
  csf_out_if.source                           out_o
);
  import csf_pkg::*;

  localparam int unsigned IDX_W  = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
  localparam int unsigned WALK_W = $clog2(NUM_LABELS + 1);
  localparam int unsigned CMP_W  = (COUNT_BITS > MIN_PIXELS_W) ? COUNT_BITS : MIN_PIXELS_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [WALK_W-1:0]     WALK_END = WALK_W'(NUM_LABELS);

  back_state_e state_q, state_d;

  logic [COUNT_BITS-1:0] cnt_mem [NUM_LABELS];
  logic [LABEL_W-1:0]    map_mem [NUM_LABELS];
  logic [COUNT_BITS-1:0] cnt_rdata_q;
  logic [LABEL_W-1:0]    map_rdata_q;

  logic [NUM_LABELS-1:0] cnt_vld_q, cnt_vld_d;
  logic                  map_built_q, map_built_d;
  logic [LABEL_W-1:0]    kept_total_q, kept_total_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [WALK_W-1:0]     walk_q, walk_d;
  logic                  stg_vld_q, stg_vld_d;
  logic [IDX_W-1:0]      stg_idx_q, stg_idx_d;
  logic [LABEL_W-1:0]    kept_q, kept_d;

  logic                  out_vld_q, out_vld_d;
  logic [LABEL_W-1:0]    out_nl_q, out_kept_q;
  logic                  out_sat_q;

  logic                  out_free;
  logic [LABEL_W-1:0]    label_m1;
  logic [IDX_W-1:0]      item_idx;

  logic                  cnt_rd;
  logic [IDX_W-1:0]      cnt_raddr;
  logic                  cnt_wr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  map_rd;
  logic                  map_wr;
  logic [LABEL_W-1:0]    map_wdata;
  logic                  emit;
  logic [LABEL_W-1:0]    em_nl, em_kept;
  logic                  em_sat;

  logic [COUNT_BITS-1:0] cur_cnt, inc_cnt, stg_cnt;
  logic                  keep;

  assign out_free = !out_vld_q || out_o.ready;
  assign label_m1 = item_i.label - LABEL_W'(1);
  assign item_idx = label_m1[IDX_W-1:0];

  assign cur_cnt = cnt_vld_q[idx_q] ? cnt_rdata_q : '0;
  assign inc_cnt = (cur_cnt != CNT_MAX) ? cur_cnt + COUNT_BITS'(1) : cur_cnt;
  assign stg_cnt = cnt_vld_q[stg_idx_q] ? cnt_rdata_q : '0;
  assign keep    = (LABEL_W'(stg_idx_q) < class_count_i) &&
                   (CMP_W'(stg_cnt) >= CMP_W'(min_pixels_i));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (valid_i && out_free) begin
          unique case (item_i.cmd)
            CMD_COUNT:   if (item_i.cluster) state_d = ST_COUNT_WR;
            CMD_RELABEL: if (item_i.cluster) state_d = ST_RELABEL_OUT;
            CMD_BUILD:   state_d = ST_BUILD_RUN;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_COUNT_WR:    state_d = ST_IDLE;
      ST_RELABEL_OUT: state_d = ST_IDLE;
      ST_BUILD_RUN:   if (stg_vld_q && (walk_q == WALK_END)) state_d = ST_BUILD_DONE;
      ST_BUILD_DONE:  state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o        = 1'b0;
    cnt_rd       = 1'b0;
    cnt_raddr    = item_idx;
    cnt_wr       = 1'b0;
    cnt_wdata    = inc_cnt;
    map_rd       = 1'b0;
    map_wr       = 1'b0;
    map_wdata    = '0;
    emit         = 1'b0;
    em_nl        = '0;
    em_kept      = kept_total_q;
    em_sat       = 1'b0;
    cnt_vld_d    = cnt_vld_q;
    map_built_d  = map_built_q;
    kept_total_d = kept_total_q;
    idx_d        = idx_q;
    walk_d       = walk_q;
    stg_vld_d    = 1'b0;
    stg_idx_d    = stg_idx_q;
    kept_d       = kept_q;
    unique case (state_q)
      ST_IDLE: begin
        if (valid_i && out_free) begin
          pop_o = 1'b1;
          idx_d = item_idx;
          unique case (item_i.cmd)
            CMD_CLEAR: begin
              cnt_vld_d = '0;
              emit      = 1'b1;
            end
            CMD_COUNT: begin
              cnt_rd = item_i.cluster;
              emit   = !item_i.cluster;
            end
            CMD_RELABEL: begin
              cnt_rd = item_i.cluster;
              map_rd = item_i.cluster;
              emit   = !item_i.cluster;
            end
            CMD_BUILD: begin
              walk_d = '0;
              kept_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_COUNT_WR: begin
        cnt_wr           = 1'b1;
        cnt_vld_d[idx_q] = 1'b1;
        emit             = 1'b1;
        em_sat           = (inc_cnt == CNT_MAX);
      end
      ST_RELABEL_OUT: begin
        emit   = 1'b1;
        em_nl  = map_built_q ? map_rdata_q : '0;
        em_sat = cnt_vld_q[idx_q] && (cnt_rdata_q == CNT_MAX);
      end
      ST_BUILD_RUN: begin
        if (walk_q != WALK_END) begin
          cnt_rd    = 1'b1;
          cnt_raddr = walk_q[IDX_W-1:0];
          stg_vld_d = 1'b1;
          stg_idx_d = walk_q[IDX_W-1:0];
          walk_d    = walk_q + WALK_W'(1);
        end
        if (stg_vld_q) begin
          map_wr    = 1'b1;
          map_wdata = keep ? kept_q + LABEL_W'(1) : '0;
          kept_d    = keep ? kept_q + LABEL_W'(1) : kept_q;
        end
      end
      ST_BUILD_DONE: begin
        kept_total_d = kept_q;
        map_built_d  = 1'b1;
        emit         = 1'b1;
        em_kept      = kept_q;
      end
      default: ;
    endcase
    out_vld_d = emit ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_vld_q    <= '0;
      map_built_q  <= 1'b0;
      kept_total_q <= '0;
      stg_vld_q    <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_vld_q    <= cnt_vld_d;
      map_built_q  <= map_built_d;
      kept_total_q <= kept_total_d;
      stg_vld_q    <= stg_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    walk_q    <= walk_d;
    stg_idx_q <= stg_idx_d;
    kept_q    <= kept_d;
    if (emit) begin
      out_nl_q   <= em_nl;
      out_kept_q <= em_kept;
      out_sat_q  <= em_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_wr) begin
      cnt_mem[idx_q] <= cnt_wdata;
    end
    if (cnt_rd) begin
      cnt_rdata_q <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_wr) begin
      map_mem[stg_idx_q] <= map_wdata;
    end
    if (map_rd) begin
      map_rdata_q <= map_mem[item_idx];
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.new_label       = out_nl_q;
  assign out_o.kept_clusters   = out_kept_q;
  assign out_o.count_saturated = out_sat_q;

endmodule

>>> design/cluster_size_filter_relabel_top.sv
// Top level of the cluster size filter with label compaction.
// Pixel labels stream in on in_i with a 2-bit command (clear, count, build, relabel) and each
// item gives exactly one result on out_o. Clear items and pixels whose label is 0 or above
// NUM_LABELS are answered straight from idle; count and relabel items on cluster labels first
// read the counter memory (relabel also the remap memory) and a count then writes it back;
// a build walks one label per cycle through the counter memory into the remap memory. A
// two-entry queue sits between input and memory engine; results wait in an output register,
// so either side may stall. Clear empties the counters. The user must write min_pixels
// (address 0) and class_count (address 4) over the APB port only while idle (not enforced).
module cluster_size_filter_relabel_top #(
  parameter int unsigned COUNT_BITS = 21,
  parameter int unsigned NUM_LABELS = 254
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  csf_in_if.sink                              in_i,
  csf_out_if.source                           out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [csf_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [csf_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [csf_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import csf_pkg::*;

  logic [MIN_PIXELS_W-1:0] min_pixels_q, min_pixels_d;
  logic [LABEL_W-1:0]      class_count_q, class_count_d;
  logic                    cfg_wr;

  logic  push;
  logic  full;
  item_t front_item;
  logic  q_valid;
  item_t q_item;
  logic  pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    min_pixels_d  = min_pixels_q;
    class_count_d = class_count_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_MIN_PIXELS:  min_pixels_d  = pwdata[MIN_PIXELS_W-1:0];
        REG_CLASS_COUNT: class_count_d = pwdata[LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MIN_PIXELS:  prdata = APB_DATA_W'(min_pixels_q);
      REG_CLASS_COUNT: prdata = APB_DATA_W'(class_count_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pixels_q  <= MIN_PIXELS_INIT;
      class_count_q <= CLASS_COUNT_INIT;
    end else begin
      min_pixels_q  <= min_pixels_d;
      class_count_q <= class_count_d;
    end
  end

  csf_front #(
    .NUM_LABELS (NUM_LABELS)
  ) u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  csf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  csf_back #(
    .COUNT_BITS (COUNT_BITS),
    .NUM_LABELS (NUM_LABELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .item_i        (q_item),
    .pop_o         (pop),
    .min_pixels_i  (min_pixels_q),
    .class_count_i (class_count_q),
    .out_o         (out_o)
  );

endmodule
